FILE: design/mpfb_pkg.sv
// Shared constants, types and helpers for the monochrome page frame store.
package mpfb_pkg;

  // Screen geometry and the store shape that follows from it.
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int PG_W          = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  // Action codes carried by the input channel.
  typedef enum logic [2:0] {
    ACT_SET    = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_RDPIX  = 3'd2,
    ACT_CLRALL = 3'd3,
    ACT_SHIFT  = 3'd4,
    ACT_RDBYTE = 3'd5
  } action_t;

  // Store access request from the sequencer to the memory.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic       valid;
    logic       pixel_on;
    logic [7:0] stored_byte;
  } result_t;

  // Store address of the byte at a page and column.
  function automatic logic [ADDR_W-1:0] byte_addr(input logic [PG_W-1:0]  pg,
                                                  input logic [COL_W-1:0] col);
    byte_addr = ADDR_W'(pg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
  endfunction

endpackage

FILE: design/mpfb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered and valid in the cycle after the request.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/mpfb_ctrl.sv
// Sequencer: pixel read-modify-write, byte reads, store clearing and the page shift walk.
module mpfb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [7:0]         in_column,
  input  logic [7:0]         in_row,
  input  logic [2:0]         in_page,
  input  logic [7:0]         in_shift_rows,
  output mpfb_pkg::mem_req_t mem_req,
  input  logic [7:0]         rd_data,
  input  logic               out_free,
  output mpfb_pkg::result_t  res
);
  import mpfb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,
    S_RESP = 7'b0000100,
    S_CLR  = 7'b0001000,
    S_SHA  = 7'b0010000,
    S_SHB  = 7'b0100000,
    S_SHW  = 7'b1000000
  } state_t;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [PG_W-1:0]  PG_MAX  = PG_W'(PAGE_COUNT - 1);

  state_t            state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic              ok_r, ok_nxt;
  logic [2:0]        bit_sel_r, bit_sel_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic [PG_W-1:0]   p_r, p_nxt;
  logic [COL_W-1:0]  x_r, x_nxt;
  logic [7:0]        h_r, h_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic              hi_zero_r, hi_zero_nxt;
  logic              lo_zero_r, lo_zero_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic              init_r, init_nxt;
  logic              res_pix_r, res_pix_nxt;
  logic [7:0]        res_byte_r, res_byte_nxt;

  logic              accept;
  logic              col_ok, row_ok, pg_ok, shift_full;
  logic [ADDR_W-1:0] pix_addr, rdb_addr, sweep_addr;
  logic              sweep_last;
  logic [7:0]        q_hi, q_lo;
  logic [7:0]        mask;
  logic [15:0]       sh_word, sh_moved;
  logic              mod_pix;
  logic [7:0]        mod_byte;

  // Decode of the incoming item.
  assign accept     = in_valid && !in_stall;
  assign col_ok     = {1'b0, in_column} < 9'(SCREEN_WIDTH);
  assign row_ok     = {1'b0, in_row} < 9'(SCREEN_HEIGHT);
  assign pg_ok      = {5'b0, in_page} < 8'(PAGE_COUNT);
  assign shift_full = {1'b0, in_shift_rows} >= 9'(SCREEN_HEIGHT);
  assign pix_addr   = byte_addr(PG_W'(in_row[7:3]), COL_W'(in_column));
  assign rdb_addr   = byte_addr(PG_W'(in_page), COL_W'(in_column));

  // Sweep position and the two source pages of a shifted byte.
  assign sweep_addr = byte_addr(p_r, x_r);
  assign sweep_last = (x_r == COL_MAX) && (p_r == PG_MAX);
  assign q_hi       = 8'(p_r) + {3'b000, h_r[7:3]};
  assign q_lo       = q_hi + 8'd1;

  // Merge the two source bytes and move them up by the row offset in the page.
  assign sh_word  = {hi_r, (lo_zero_r ? 8'h00 : rd_data)};
  assign sh_moved = sh_word << h_r[2:0];

  assign mask     = 8'h80 >> bit_sel_r;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    ok_nxt       = ok_r;
    bit_sel_nxt  = bit_sel_r;
    wa_nxt       = wa_r;
    p_nxt        = p_r;
    x_nxt        = x_r;
    h_nxt        = h_r;
    hi_nxt       = hi_r;
    hi_zero_nxt  = hi_zero_r;
    lo_zero_nxt  = lo_zero_r;
    wr_pend_nxt  = wr_pend_r;
    init_nxt     = init_r;
    res_pix_nxt  = res_pix_r;
    res_byte_nxt = res_byte_r;
    mem_req      = '0;
    res          = '0;
    mod_pix      = 1'b0;
    mod_byte     = 8'h00;

    unique case (state_r)
      // Take a new item and start its work.
      S_IDLE: begin
        if (accept) begin
          act_nxt      = action_t'(in_action);
          bit_sel_nxt  = in_row[2:0];
          res_pix_nxt  = 1'b0;
          res_byte_nxt = 8'h00;
          p_nxt        = '0;
          x_nxt        = '0;
          wr_pend_nxt  = 1'b0;
          h_nxt        = in_shift_rows;
          unique case (action_t'(in_action))
            ACT_SET, ACT_CLEAR, ACT_RDPIX: begin
              mem_req.rd_en   = col_ok && row_ok;
              mem_req.rd_addr = pix_addr;
              wa_nxt          = pix_addr;
              ok_nxt          = col_ok && row_ok;
              state_nxt       = S_MOD;
            end
            ACT_RDBYTE: begin
              mem_req.rd_en   = col_ok && pg_ok;
              mem_req.rd_addr = rdb_addr;
              ok_nxt          = col_ok && pg_ok;
              state_nxt       = S_MOD;
            end
            ACT_CLRALL: begin
              state_nxt = S_CLR;
            end
            ACT_SHIFT: begin
              priority if (in_shift_rows == 8'd0) begin
                state_nxt = S_RESP;
              end else if (shift_full) begin
                state_nxt = S_CLR;
              end else begin
                state_nxt = S_SHA;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // Store byte is back: modify and write, or pick out the result.
      S_MOD: begin
        unique case (act_r)
          ACT_SET: begin
            mem_req.wr_en   = ok_r;
            mem_req.wr_addr = wa_r;
            mem_req.wr_data = rd_data | mask;
          end
          ACT_CLEAR: begin
            mem_req.wr_en   = ok_r;
            mem_req.wr_addr = wa_r;
            mem_req.wr_data = rd_data & ~mask;
          end
          ACT_RDPIX: begin
            mod_pix = ok_r && ((rd_data & mask) != 8'h00);
          end
          ACT_RDBYTE: begin
            mod_byte = ok_r ? rd_data : 8'h00;
          end
          default: begin
          end
        endcase
        if (out_free) begin
          res.valid       = 1'b1;
          res.pixel_on    = mod_pix;
          res.stored_byte = mod_byte;
          state_nxt       = S_IDLE;
        end else begin
          res_pix_nxt  = mod_pix;
          res_byte_nxt = mod_byte;
          state_nxt    = S_RESP;
        end
      end

      // Hold the result until the output register can take it.
      S_RESP: begin
        if (out_free) begin
          res.valid       = 1'b1;
          res.pixel_on    = res_pix_r;
          res.stored_byte = res_byte_r;
          state_nxt       = S_IDLE;
        end
      end

      // Clearing pass, one byte a cycle; also run after reset.
      S_CLR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = sweep_addr;
        mem_req.wr_data = 8'h00;
        x_nxt           = (x_r == COL_MAX) ? '0 : x_r + COL_W'(1);
        p_nxt           = (x_r == COL_MAX) ? p_r + PG_W'(1) : p_r;
        if (sweep_last) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_RESP;
        end
      end

      // Shift walk, first phase: fetch the upper source byte and write back
      // the byte finished in the previous pass.
      S_SHA: begin
        hi_zero_nxt     = q_hi >= 8'(PAGE_COUNT);
        mem_req.rd_en   = q_hi < 8'(PAGE_COUNT);
        mem_req.rd_addr = byte_addr(PG_W'(q_hi), x_r);
        mem_req.wr_en   = wr_pend_r;
        mem_req.wr_addr = wa_r;
        mem_req.wr_data = sh_moved[15:8];
        state_nxt       = S_SHB;
      end

      // Shift walk, second phase: capture the upper byte, fetch the lower one.
      S_SHB: begin
        hi_nxt          = hi_zero_r ? 8'h00 : rd_data;
        lo_zero_nxt     = q_lo >= 8'(PAGE_COUNT);
        mem_req.rd_en   = q_lo < 8'(PAGE_COUNT);
        mem_req.rd_addr = byte_addr(PG_W'(q_lo), x_r);
        wa_nxt          = sweep_addr;
        wr_pend_nxt     = 1'b1;
        x_nxt           = (x_r == COL_MAX) ? '0 : x_r + COL_W'(1);
        p_nxt           = (x_r == COL_MAX) ? p_r + PG_W'(1) : p_r;
        state_nxt       = sweep_last ? S_SHW : S_SHA;
      end

      // Write back the last shifted byte.
      S_SHW: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = wa_r;
        mem_req.wr_data = sh_moved[15:8];
        wr_pend_nxt     = 1'b0;
        state_nxt       = S_RESP;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      init_r    <= 1'b1;
      p_r       <= '0;
      x_r       <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      init_r    <= init_nxt;
      p_r       <= p_nxt;
      x_r       <= x_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    ok_r       <= ok_nxt;
    bit_sel_r  <= bit_sel_nxt;
    wa_r       <= wa_nxt;
    h_r        <= h_nxt;
    hi_r       <= hi_nxt;
    hi_zero_r  <= hi_zero_nxt;
    lo_zero_r  <= lo_zero_nxt;
    res_pix_r  <= res_pix_nxt;
    res_byte_r <= res_byte_nxt;
  end

  // A read and a write in the same cycle never touch the same byte.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_addr != mem_req.wr_addr)
    else $error("read and write to the same store byte in one cycle");

  // No transfer is taken while the clearing pass after reset runs.
  a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> in_stall)
    else $error("input transfer during the reset clearing pass");

  // A result is only offered when the output register can take it.
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result offered to a full output register");

  // The second phase of the shift walk, the lower-byte fetch, never writes.
  a_shb_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHB |-> !mem_req.wr_en)
    else $error("store write during the lower-byte fetch of a shift");

  // A pixel write is always followed by its modify cycle.
  a_set_mod: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_SET || in_action == ACT_CLEAR) |=> state_r == S_MOD)
    else $error("pixel write accepted without a modify cycle");

endmodule

FILE: design/mono_page_framebuffer_engine.sv
// Top level of the monochrome page frame store: sequencer, store RAM, output register.
// Pixel and byte actions pass through the modify state, and the hold state while the output
// register is full, into the output register; in_stall stays high until the result is taken.
// Clear all writes zero to all STORE_DEPTH (1024) store bytes, one store write a cycle.
// A shift fetches the upper and lower source bytes of each store byte through the one read port.
// After reset a clearing pass over all STORE_DEPTH bytes runs with in_stall held high.
module mono_page_framebuffer_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_column,
  input  logic [7:0] in_row,
  input  logic [2:0] in_page,
  input  logic [7:0] in_shift_rows,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pixel_on,
  output logic [7:0] out_stored_byte
);
  import mpfb_pkg::*;

  mem_req_t   mem_req;
  result_t    res;
  logic [7:0] rd_data;
  logic       out_free;
  logic       out_valid_r, out_valid_nxt;
  logic       out_pix_r;
  logic [7:0] out_byte_r;

  // Sequencer.
  mpfb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_page       (in_page),
    .in_shift_rows (in_shift_rows),
    .mem_req       (mem_req),
    .rd_data       (rd_data),
    .out_free      (out_free),
    .res           (res)
  );

  // Frame store.
  mpfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // Output register: free when empty or when its transfer completes now.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_pix_r  <= res.pixel_on;
      out_byte_r <= res.stored_byte;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_on    = out_pix_r;
  assign out_stored_byte = out_byte_r;

endmodule
